// ===== hw/rtl/md5hx_pkg.sv =====
package md5hx_pkg;

    localparam int unsigned CharWidth    = 8;
    localparam int unsigned HalfWidth    = 64;
    localparam int unsigned MarkerLen    = 5;
    localparam int unsigned ProgWidth    = 3;
    localparam int unsigned CountWidth   = 6;
    localparam int unsigned DigestDigits = 32;
    localparam int unsigned DigitsPerHalf = 16;
    localparam int unsigned OutDataWidth = 136;

    localparam logic [CharWidth-1:0] CharNewline = 8'h0A;
    localparam logic [CharWidth-1:0] CharM       = 8'h4D;
    localparam logic [CharWidth-1:0] CharD       = 8'h44;
    localparam logic [CharWidth-1:0] Char5       = 8'h35;
    localparam logic [CharWidth-1:0] CharEq      = 8'h3D;

    localparam logic [CountWidth-1:0] LastDigitIdx = CountWidth'(DigestDigits - 1);

    typedef struct packed {
        logic                 valid;
        logic [3:0]           value;
    } t_hex;

    typedef struct packed {
        logic                 found;
        logic [HalfWidth-1:0] first_half;
        logic [HalfWidth-1:0] second_half;
    } t_result;

    // marker character expected at a given match position
    function automatic logic [CharWidth-1:0] marker_char(input logic [ProgWidth-1:0] pos);
        logic [CharWidth-1:0] ch;
        unique case (pos)
            3'd0:    ch = CharNewline;
            3'd1:    ch = CharM;
            3'd2:    ch = CharD;
            3'd3:    ch = Char5;
            3'd4:    ch = CharEq;
            default: ch = CharNewline;
        endcase
        return ch;
    endfunction

    function automatic t_hex hex_decode(input logic [CharWidth-1:0] c);
        t_hex h;
        h.valid = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.valid = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/md5hx_scan.sv =====
module md5hx_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [md5hx_pkg::CharWidth-1:0]     i_char,
    input  logic                                i_last,
    output md5hx_pkg::t_result                  o_result
);

    logic [md5hx_pkg::ProgWidth-1:0]  r_prog, n_prog;
    logic                             r_coll, n_coll;
    logic [md5hx_pkg::CountWidth-1:0] r_cnt, n_cnt;
    logic [md5hx_pkg::HalfWidth-1:0]  r_d0, n_d0;
    logic [md5hx_pkg::HalfWidth-1:0]  r_d1, n_d1;
    logic                             r_found, n_found;

    logic [md5hx_pkg::ProgWidth-1:0]  m_pos;
    logic [md5hx_pkg::ProgWidth-1:0]  m_pos_inc;
    logic [md5hx_pkg::ProgWidth-1:0]  m_prog;
    logic                             m_start;
    md5hx_pkg::t_hex                  hex;

    // marker matcher on the current character
    always_comb begin
        m_pos     = (r_prog < md5hx_pkg::ProgWidth'(md5hx_pkg::MarkerLen)) ? r_prog : '0;
        m_pos_inc = m_pos + md5hx_pkg::ProgWidth'(1);
        m_start   = 1'b0;
        if (i_char == md5hx_pkg::marker_char(m_pos)) begin
            if (m_pos_inc == md5hx_pkg::ProgWidth'(md5hx_pkg::MarkerLen)) begin
                m_start = 1'b1;
                m_prog  = '0;
            end else begin
                m_prog  = m_pos_inc;
            end
        end else begin
            m_prog = (i_char == md5hx_pkg::CharNewline) ? md5hx_pkg::ProgWidth'(1) : '0;
        end
    end

    assign hex = md5hx_pkg::hex_decode(i_char);

    always_comb begin
        n_prog  = r_prog;
        n_coll  = r_coll;
        n_cnt   = r_cnt;
        n_d0    = r_d0;
        n_d1    = r_d1;
        n_found = r_found;
        if (!r_found) begin
            if (r_coll && hex.valid) begin
                // first sixteen digits fill the first half
                if (r_cnt[4]) begin
                    n_d1 = {r_d1[md5hx_pkg::HalfWidth-5:0], hex.value};
                end else begin
                    n_d0 = {r_d0[md5hx_pkg::HalfWidth-5:0], hex.value};
                end
                n_cnt = r_cnt + md5hx_pkg::CountWidth'(1);
                if (r_cnt == md5hx_pkg::LastDigitIdx) begin
                    n_found = 1'b1;
                    n_coll  = 1'b0;
                end
            end else begin
                // broken candidate or plain scan: char is tried as marker
                if (r_coll) begin
                    n_coll = 1'b0;
                    n_cnt  = '0;
                    n_d0   = '0;
                    n_d1   = '0;
                end
                if (m_start) begin
                    n_coll = 1'b1;
                    n_cnt  = '0;
                    n_d0   = '0;
                    n_d1   = '0;
                end
                n_prog = m_prog;
            end
        end
    end

    always_comb begin
        o_result.found       = n_found;
        o_result.first_half  = n_found ? n_d0 : '0;
        o_result.second_half = n_found ? n_d1 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_prog  <= '0;
            r_coll  <= 1'b0;
            r_cnt   <= '0;
            r_d0    <= '0;
            r_d1    <= '0;
            r_found <= 1'b0;
        end else if (i_step) begin
            r_prog  <= n_prog;
            r_coll  <= n_coll;
            r_cnt   <= n_cnt;
            r_d0    <= n_d0;
            r_d1    <= n_d1;
            r_found <= n_found;
        end
    end

endmodule

// ===== hw/rtl/md5hx_out_buf.sv =====
module md5hx_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  md5hx_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output md5hx_pkg::t_result o_result
);

    logic               r_valid, n_valid;
    md5hx_pkg::t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/md5hx_hex_digest_extractor_top.sv =====
// md5 hex digest extractor
// the slave channel takes the text one character per word: tdata[7:0] is
// the character, tlast marks the final character of the text. the block
// scans for a newline followed by "MD5=" and packs the first run of 32 hex
// digits after it (either case) into a 16-byte digest.
// the master channel gives one word per text, on its last character:
// tdata[0] found, tdata[64:1] digest bytes 0..7 (byte 0 on top),
// tdata[128:65] digest bytes 8..15 (byte 8 on top), upper bits zero.
// digest bits are zero when nothing was found.
// throughput: one character per clock while no last character is held back,
// set by the scan update between the input register and the output register.
// a result word follows its last character through the input register and
// then the output register.
// when the receiver stalls, the output register holds its word; characters
// that are not last keep flowing, and a last character waits in the input
// register until the output register is free.
// reset clears the scan state and both valid flags, not the held data.
// after each last character the scan state clears for the next text.
module md5_hex_digest_extractor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // text_char
    input  logic         s_axis_tlast,   // end_of_text
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // found, digest_first_half, digest_second_half
);

    logic                                r_in_valid;
    logic [md5hx_pkg::CharWidth-1:0]     r_in_char;
    logic                                r_in_last;
    logic                                out_free;
    logic                                advance;
    logic                                in_take;
    md5hx_pkg::t_result                  scan_result;
    md5hx_pkg::t_result                  out_result;
    logic                                out_valid;

    assign out_free      = !out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    md5hx_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (scan_result)
    );

    md5hx_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_in_last),
        .i_result (scan_result),
        .i_ready  (m_axis_tready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, out_result.second_half, out_result.first_half,
                            out_result.found};

    // a new result word only follows a last character leaving the input stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(advance && r_in_last))
        else $error("result word without a last character");

    // digest is zero whenever nothing was found
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[128:1] == '0))
        else $error("digest not cleared with found low");

    // a held character is not overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("input register lost a character");

    // a last character never overwrites a pending result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |-> out_free)
        else $error("result overrun");

endmodule

// ===== tb/tb_md5_hex_digest_extractor_top.sv =====
`timescale 1ns / 100ps

module tb_md5_hex_digest_extractor_top;

    typedef logic [7:0] t_char_q[$];

    // marker characters, first one in the lowest byte
    localparam logic [39:0] MARKER_SEQ = {md5hx_pkg::CharEq, md5hx_pkg::Char5, md5hx_pkg::CharD,
                                          md5hx_pkg::CharM, md5hx_pkg::CharNewline};
    // non-hex characters right next to the hex ranges
    localparam logic [47:0] NEAR_HEX   = "/:@G`g";

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // text_char
    logic         s_axis_tlast;   // end_of_text
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // found, digest_first_half, digest_second_half

    bit tx_idle;
    bit rx_idle;
    int rx_hold;

    class digest_scoreboard;
        md5hx_pkg::t_result digest_q[$];
        int          errors;
        logic [2:0]  mark_pos;
        bit          collecting;
        logic [5:0]  digit_cnt;
        logic [63:0] acc [2];
        bit          got_digest;

        function new();
            errors = 0;
            reset_scan();
        endfunction

        function void reset_scan();
            mark_pos   = '0;
            collecting = 1'b0;
            digit_cnt  = '0;
            acc        = '{default: '0};
            got_digest = 1'b0;
        endfunction

        function void advance_marker(logic [7:0] c);
            logic [2:0] p;
            p = (mark_pos < md5hx_pkg::MarkerLen) ? mark_pos : 3'd0;
            if (c == MARKER_SEQ[p*8 +: 8]) begin
                p++;
                if (p == md5hx_pkg::MarkerLen) begin
                    collecting = 1'b1;
                    digit_cnt  = '0;
                    acc        = '{default: '0};
                    p          = '0;
                end
                mark_pos = p;
            end else begin
                mark_pos = (c == md5hx_pkg::CharNewline) ? 3'd1 : 3'd0;
            end
        endfunction

        function void note_char(logic [7:0] c, bit l);
            logic [3:0]         nib;
            bit                 is_hex;
            md5hx_pkg::t_result r;
            if (!got_digest) begin
                if (collecting) begin
                    is_hex = 1'b1;
                    nib    = '0;
                    if (c >= "0" && c <= "9") begin
                        nib = 4'(c - "0");
                    end else if (c >= "a" && c <= "f") begin
                        nib = 4'(c - "a" + 8'd10);
                    end else if (c >= "A" && c <= "F") begin
                        nib = 4'(c - "A" + 8'd10);
                    end else begin
                        is_hex = 1'b0;
                    end
                    if (is_hex) begin
                        acc[digit_cnt[4]] = {acc[digit_cnt[4]][59:0], nib};
                        digit_cnt++;
                        if (digit_cnt >= md5hx_pkg::DigestDigits) begin
                            got_digest = 1'b1;
                            collecting = 1'b0;
                        end
                    end else begin
                        // candidate dropped, char may still start a marker
                        collecting = 1'b0;
                        digit_cnt  = '0;
                        acc        = '{default: '0};
                        advance_marker(c);
                    end
                end else begin
                    advance_marker(c);
                end
            end
            if (l) begin
                r.found       = got_digest;
                r.first_half  = got_digest ? acc[0] : '0;
                r.second_half = got_digest ? acc[1] : '0;
                digest_q.push_back(r);
                reset_scan();
            end
        endfunction

        function void check_word(logic [135:0] w);
            md5hx_pkg::t_result e;
            if (digest_q.size() == 0) begin
                $error("digest word with none expected: %h", w);
                errors++;
                return;
            end
            e = digest_q.pop_front();
            if (w[0] !== e.found) begin
                $error("found: expected %0d, got %0d", e.found, w[0]);
                errors++;
            end
            if (w[64:1] !== e.first_half) begin
                $error("digest_first_half: expected %h, got %h", e.first_half, w[64:1]);
                errors++;
            end
            if (w[128:65] !== e.second_half) begin
                $error("digest_second_half: expected %h, got %h", e.second_half, w[128:65]);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    digest_scoreboard sb = new();

    md5_hex_digest_extractor_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("md5_hex_digest_extractor_top verification failed");
        $finish;
    end

    // sampled values are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
        end
    end

    // receiver
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall   = rx_hold + (rx_idle ? $urandom_range(0, 15) : 0);
            rx_hold = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [7:0] hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'("0" + $urandom_range(0, 9));
            1:       return 8'("a" + $urandom_range(0, 5));
            default: return 8'("A" + $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 3))
            0:       return md5hx_pkg::CharNewline;
            1:       return NEAR_HEX[$urandom_range(0, 5)*8 +: 8];
            2:       return md5hx_pkg::CharM;
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    // a text built from noise, markers, digest candidates and broken ones
    function automatic t_char_q make_text();
        t_char_q t;
        int      n;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(0, 8)) t.push_back(8'($urandom_range(0, 255)));
                end
                2, 3, 4, 5: begin
                    for (int i = 0; i < md5hx_pkg::MarkerLen; i++)
                        t.push_back(MARKER_SEQ[i*8 +: 8]);
                    repeat (md5hx_pkg::DigestDigits) t.push_back(hex_char());
                    repeat ($urandom_range(0, 3)) t.push_back(8'($urandom_range(0, 255)));
                end
                6: begin
                    for (int i = 0; i < md5hx_pkg::MarkerLen; i++)
                        t.push_back(MARKER_SEQ[i*8 +: 8]);
                    repeat ($urandom_range(0, md5hx_pkg::DigestDigits - 1))
                        t.push_back(hex_char());
                    t.push_back(non_hex_char());
                end
                7: begin
                    n = $urandom_range(1, md5hx_pkg::MarkerLen - 1);
                    for (int i = 0; i < n; i++) t.push_back(MARKER_SEQ[i*8 +: 8]);
                    t.push_back(non_hex_char());
                end
                8: begin
                    t.push_back(md5hx_pkg::CharNewline);
                    for (int i = 0; i < md5hx_pkg::MarkerLen; i++)
                        t.push_back(MARKER_SEQ[i*8 +: 8]);
                end
                default: begin
                    repeat ($urandom_range(1, 40)) t.push_back(hex_char());
                end
            endcase
        end
        if (t.size() == 0)
            t.push_back(8'($urandom_range(0, 255)));
        return t;
    endfunction

    task automatic send_char(logic [7:0] c, bit l);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_text(t_char_q t);
        for (int i = 0; i < t.size(); i++)
            send_char(t[i], i == t.size() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_char_q t;
        int      sent;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold       = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes, no marker
        send_text('{8'h00, 8'hFF});
        // double newline restart, empty candidate, marker broken late
        send_text('{md5hx_pkg::CharNewline, md5hx_pkg::CharNewline, md5hx_pkg::CharM,
                    md5hx_pkg::CharD, md5hx_pkg::Char5, md5hx_pkg::CharEq, "/",
                    md5hx_pkg::CharNewline, md5hx_pkg::CharM, md5hx_pkg::CharD, "X", "g"});
        // partial candidate broken by a non-hex letter
        send_text('{md5hx_pkg::CharNewline, md5hx_pkg::CharM, md5hx_pkg::CharD,
                    md5hx_pkg::Char5, md5hx_pkg::CharEq, "9", "f", "G"});
        send_text('{md5hx_pkg::CharNewline});
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            tx_idle = phase[0];
            rx_idle = phase[1];
            sent    = 0;
            while (sent < 400) begin
                t = make_text();
                send_text(t);
                sent += t.size();
            end
            drain();

            if (phase == 0) begin
                // receiver holds off while short texts keep coming
                rx_hold = 300;
                repeat (40) begin
                    t.delete();
                    repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(0, 255)));
                    send_text(t);
                end
                drain();
            end
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("md5_hex_digest_extractor_top verification clean");
        else
            $display("md5_hex_digest_extractor_top verification failed");
        $finish;
    end

endmodule
